FILE: rtl/core/dgcd_pkg.sv
// Shared types and constants of the directed-graph cycle detector.
package dgcd_pkg;

	localparam int VERTEX_LIMIT = 64;
	localparam int VID_W        = 6;
	localparam int CNT_W        = 7;

	localparam logic ACT_ADD   = 1'b0;
	localparam logic ACT_CHECK = 1'b1;

	typedef logic [VERTEX_LIMIT-1:0] row_t;

	// One search frame: the vertex and the next neighbour to examine.
	typedef struct packed {
		logic [CNT_W-1:0] k;
		logic [VID_W-1:0] v;
	} frame_t;

endpackage

FILE: rtl/core/dgcd_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module dgcd_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/core/directed_graph_cycle_detect.sv
// Directed-graph cycle detector: adjacency bit matrix in RAM and an iterative depth-first search.
//
// Each input beat either adds a directed edge (action = add) or runs a cycle check
// (action = check), which returns one result beat on has_cycle. The graph is held
// as a 64 x 64 bit matrix in a RAM, one row per source vertex; a flip-flop valid
// bit per row makes every row read as empty after reset, so no clearing pass is
// needed. Edges with an endpoint at or above the vertex count are dropped and leave
// the RAM untouched; a stored add reads the row, then updates it and writes it back
// through the single RAM port pair. A check examines one neighbour per cycle from
// the adjacency row held in a register, so its length depends on the graph: it tries
// each root vertex in turn, scans the neighbours of every vertex visited, fetches the
// row of each vertex pushed and, on a pop to a parent, fetches the parent frame from
// the stack RAM and then its row; a final state posts the result once the output
// is free. The search stops at the first edge that closes a path, and a self-loop
// counts as a cycle. The search stack lives in a second RAM of MAX_V frames, with
// the top frame kept in registers. While a check runs no input beat is taken; the
// result register lets the next beat be accepted while the result still waits to
// be collected. The vertex count is written through the cfg port and must only
// change while the block is idle.
module directed_graph_cycle_detect #(
	parameter int MAX_V = 64
) (
	input  logic       clk,
	input  logic       arst_n,

	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [6:0] cfg_data,

	input  logic       in_valid,
	output logic       in_ready,
	input  logic       action,
	input  logic [5:0] edge_from,
	input  logic [5:0] edge_to,

	output logic       out_valid,
	input  logic       out_ready,
	output logic       has_cycle
);

	localparam int DEPTH_W = $clog2(MAX_V + 1);
	localparam int SADDR_W = $clog2(MAX_V);
	localparam int LIMIT   = (MAX_V < dgcd_pkg::VERTEX_LIMIT) ? MAX_V : dgcd_pkg::VERTEX_LIMIT;
	localparam logic [dgcd_pkg::CNT_W-1:0] LIMIT_C = dgcd_pkg::CNT_W'(LIMIT);
	localparam logic [DEPTH_W-1:0]         MAXV_D  = DEPTH_W'(MAX_V);
	localparam logic [DEPTH_W-1:0]         ONE_D   = DEPTH_W'(1);
	localparam logic [DEPTH_W-1:0]         TWO_D   = DEPTH_W'(2);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD_WR,
		ST_ROOT,
		ST_LOAD,
		ST_SCAN,
		ST_POP_RD,
		ST_FINISH
	} state_t;

	state_t state_q;

	logic [dgcd_pkg::CNT_W-1:0] vertex_count_q;
	logic [dgcd_pkg::CNT_W-1:0] n_eff;

	logic [dgcd_pkg::VERTEX_LIMIT-1:0] row_valid_q;
	logic                              adj_valid_s1;
	dgcd_pkg::row_t                    visited_q;
	dgcd_pkg::row_t                    on_path_q;
	dgcd_pkg::row_t                    row_q;

	logic [dgcd_pkg::VID_W-1:0] from_q;
	logic [dgcd_pkg::VID_W-1:0] to_q;
	logic [dgcd_pkg::VID_W-1:0] top_v_q;
	logic [dgcd_pkg::CNT_W-1:0] top_k_q;
	logic [dgcd_pkg::CNT_W-1:0] root_q;
	logic [DEPTH_W-1:0]         depth_q;
	logic                       cycle_q;
	logic                       out_valid_q;
	logic                       has_cycle_q;

	// Adjacency RAM port signals.
	logic                       adj_we;
	logic [dgcd_pkg::VID_W-1:0] adj_waddr;
	dgcd_pkg::row_t             adj_wdata;
	logic                       adj_re;
	logic [dgcd_pkg::VID_W-1:0] adj_raddr;
	dgcd_pkg::row_t             adj_rdata;
	dgcd_pkg::row_t             adj_row;

	// Stack RAM port signals.
	logic                       stk_we;
	logic [SADDR_W-1:0]         stk_waddr;
	dgcd_pkg::frame_t           stk_wdata;
	logic                       stk_re;
	logic [SADDR_W-1:0]         stk_raddr;
	dgcd_pkg::frame_t           stk_rdata;

	logic                       in_beat;
	logic                       add_go;
	logic [dgcd_pkg::VID_W-1:0] k_idx;
	logic [dgcd_pkg::VID_W-1:0] root_idx;
	logic                       scan_end;
	logic                       edge_hit;
	logic                       cyc_hit;
	logic                       push;
	logic                       root_push;
	logic [DEPTH_W-1:0]         depth_m1;
	logic [DEPTH_W-1:0]         depth_m2;

	// The count in use saturates at the smaller of 64 and the stack depth.
	assign n_eff = (vertex_count_q > LIMIT_C) ? LIMIT_C : vertex_count_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign has_cycle = has_cycle_q;

	assign in_beat  = in_valid && in_ready;
	assign k_idx    = top_k_q[dgcd_pkg::VID_W-1:0];
	assign root_idx = root_q[dgcd_pkg::VID_W-1:0];
	assign depth_m1 = depth_q - ONE_D;
	assign depth_m2 = depth_q - TWO_D;

	// A row that has never been written reads as empty.
	assign adj_row = adj_valid_s1 ? adj_rdata : '0;

	always_comb begin
		add_go = in_beat && (action == dgcd_pkg::ACT_ADD) &&
		         ({1'b0, edge_from} < n_eff) && ({1'b0, edge_to} < n_eff);

		scan_end = (top_k_q >= n_eff);
		edge_hit = row_q[k_idx];
		cyc_hit  = (state_q == ST_SCAN) && !scan_end && edge_hit && on_path_q[k_idx];
		push     = (state_q == ST_SCAN) && !scan_end && edge_hit && !on_path_q[k_idx] &&
		           !visited_q[k_idx] && (depth_q < MAXV_D);
		root_push = (state_q == ST_ROOT) && (root_q < n_eff) && !visited_q[root_idx];

		adj_re = add_go || root_push || push || (state_q == ST_POP_RD);
		case (state_q)
			ST_ROOT:   adj_raddr = root_idx;
			ST_SCAN:   adj_raddr = k_idx;
			ST_POP_RD: adj_raddr = stk_rdata.v;
			default:   adj_raddr = edge_from;
		endcase

		adj_we    = (state_q == ST_ADD_WR);
		adj_waddr = from_q;
		adj_wdata = adj_row | (dgcd_pkg::row_t'(1) << to_q);

		// The frame below the new top is saved with its neighbour index already advanced.
		stk_we         = push;
		stk_waddr      = depth_m1[SADDR_W-1:0];
		stk_wdata.k    = top_k_q + dgcd_pkg::CNT_W'(1);
		stk_wdata.v    = top_v_q;
		stk_re         = (state_q == ST_SCAN) && scan_end && (depth_q != ONE_D);
		stk_raddr      = depth_m2[SADDR_W-1:0];
	end

	dgcd_ram #(
		.WIDTH (dgcd_pkg::VERTEX_LIMIT),
		.DEPTH (dgcd_pkg::VERTEX_LIMIT)
	) u_adj_ram (
		.clk   (clk),
		.we    (adj_we),
		.waddr (adj_waddr),
		.wdata (adj_wdata),
		.re    (adj_re),
		.raddr (adj_raddr),
		.rdata (adj_rdata)
	);

	dgcd_ram #(
		.WIDTH ($bits(dgcd_pkg::frame_t)),
		.DEPTH (MAX_V)
	) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// The row valid bit travels with the RAM read so that it lines up with the data.
	always_ff @(posedge clk) begin
		if (adj_re) begin
			adj_valid_s1 <= row_valid_q[adj_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			vertex_count_q <= dgcd_pkg::CNT_W'(dgcd_pkg::VERTEX_LIMIT);
			row_valid_q    <= '0;
			visited_q      <= '0;
			on_path_q      <= '0;
			row_q          <= '0;
			from_q         <= '0;
			to_q           <= '0;
			top_v_q        <= '0;
			top_k_q        <= '0;
			depth_q        <= '0;
			root_q         <= '0;
			cycle_q        <= 1'b0;
			out_valid_q    <= 1'b0;
			has_cycle_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				vertex_count_q <= cfg_data;
			end
			if (out_valid_q && out_ready && (state_q != ST_FINISH)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (add_go) begin
						from_q  <= edge_from;
						to_q    <= edge_to;
						state_q <= ST_ADD_WR;
					end else if (in_beat && (action == dgcd_pkg::ACT_CHECK)) begin
						visited_q <= '0;
						on_path_q <= '0;
						depth_q   <= '0;
						root_q    <= '0;
						state_q   <= ST_ROOT;
					end
				end
				ST_ADD_WR: begin
					row_valid_q[from_q] <= 1'b1;
					state_q             <= ST_IDLE;
				end
				ST_ROOT: begin
					if (root_q >= n_eff) begin
						cycle_q <= 1'b0;
						state_q <= ST_FINISH;
					end else begin
						root_q <= root_q + dgcd_pkg::CNT_W'(1);
						if (root_push) begin
							top_v_q             <= root_idx;
							top_k_q             <= '0;
							visited_q[root_idx] <= 1'b1;
							on_path_q[root_idx] <= 1'b1;
							depth_q             <= ONE_D;
							state_q             <= ST_LOAD;
						end
					end
				end
				ST_LOAD: begin
					row_q   <= adj_row;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_end) begin
						on_path_q[top_v_q] <= 1'b0;
						depth_q            <= depth_m1;
						state_q            <= (depth_q == ONE_D) ? ST_ROOT : ST_POP_RD;
					end else if (cyc_hit) begin
						depth_q <= '0;
						cycle_q <= 1'b1;
						state_q <= ST_FINISH;
					end else if (push) begin
						top_v_q          <= k_idx;
						top_k_q          <= '0;
						visited_q[k_idx] <= 1'b1;
						on_path_q[k_idx] <= 1'b1;
						depth_q          <= depth_q + ONE_D;
						state_q          <= ST_LOAD;
					end else begin
						top_k_q <= top_k_q + dgcd_pkg::CNT_W'(1);
					end
				end
				ST_POP_RD: begin
					top_v_q <= stk_rdata.v;
					top_k_q <= stk_rdata.k;
					state_q <= ST_LOAD;
				end
				ST_FINISH: begin
					// A waiting result that is collected now makes room for this one.
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						has_cycle_q <= cycle_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/dgcd_checker.sv
// Port-level assertions for the cycle detector and the bind that attaches them.
module dgcd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       action,
	input logic       out_valid,
	input logic       out_ready,
	input logic       has_cycle
);

	// A result beat that is held back keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(has_cycle))
		else $error("result beat changed while stalled");

	// An add beat never produces a result.
	a_add_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (action == dgcd_pkg::ACT_ADD) && !out_valid |=> !out_valid)
		else $error("result beat raised by an add");

	// A check keeps the input side closed while the search runs.
	a_check_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (action == dgcd_pkg::ACT_CHECK) |=> !in_ready)
		else $error("input beat taken during a check");

	// A check's result beat never comes straight after the check beat is taken.
	a_check_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (action == dgcd_pkg::ACT_CHECK) && !out_valid |=> !out_valid)
		else $error("result beat appeared too early");

endmodule

bind directed_graph_cycle_detect dgcd_checker u_dgcd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.action    (action),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.has_cycle (has_cycle)
);

FILE: tb/tb_directed_graph_cycle_detect.sv
// Self-checking testbench for the directed-graph cycle detector.
`timescale 1ns / 100ps

module tb_directed_graph_cycle_detect;

	// Depth of the search stack in the instance, kept equal to the vertex limit so that the
	// stack can never fill.
	localparam int STACK_FRAMES = 64;
	// Random beats that change the graph or ask for a check; dropped adds come on top.
	localparam int RANDOM_BEATS = 1850;
	// Idle cycles let pass after the last result before the vertex count is rewritten. A stored
	// add finishes its read-modify-write well within them.
	localparam int SETTLE_CYCLES = 8;
	// Slowest honest run: every beat a full search of 64 vertices, plus the longest receiver
	// stall and sender gap. The limit is a few times that.
	localparam int CYCLE_LIMIT = 30_000_000;

	localparam logic NO_CYCLE  = 1'b0;
	localparam logic CYCLE     = 1'b1;
	localparam logic TYPED     = 1'b1;
	localparam logic PREDICTED = 1'b0;

	typedef enum logic {STEP_BEAT, STEP_COUNT} step_kind_t;

	// One row of the directed script: either an input beat or a write of the vertex count.
	// Where the answer of a check is obvious it is typed into the row; otherwise the
	// predictor supplies it.
	typedef struct packed {
		step_kind_t kind;
		logic       act;
		logic [5:0] src;
		logic [5:0] dst;
		logic [6:0] count;
		logic       known;
		logic       answer;
	} script_row_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [6:0] cfg_data  = '0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	logic       action    = dgcd_pkg::ACT_ADD;
	logic [5:0] edge_from = '0;
	logic [5:0] edge_to   = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       has_cycle;

	// Predictor state: our own copy of the adjacency matrix and of the vertex count.
	dgcd_pkg::row_t graph_rows [dgcd_pkg::VERTEX_LIMIT];
	logic [6:0]     set_count = 7'd64;

	// Answers still owed by the block, oldest first.
	logic       cycle_answers [$];
	script_row_t script [$];

	int mismatches     = 0;
	int cycle_count    = 0;
	int checks_sent    = 0;
	int cycles_seen    = 0;
	int edges_stored   = 0;
	int edges_dropped  = 0;
	int count_writes   = 0;
	int changing_beats = 0;
	int burst_left     = 0;
	int rx_mode        = 0;
	int rx_left        = 0;
	int rx_hold        = 0;

	directed_graph_cycle_detect #(
		.MAX_V(STACK_FRAMES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.edge_from(edge_from),
		.edge_to(edge_to),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.has_cycle(has_cycle)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Number of vertices a search really covers: the register saturates at the matrix size.
	function automatic int live_vertices();
		int n;
		n = set_count;
		if (n > dgcd_pkg::VERTEX_LIMIT) n = dgcd_pkg::VERTEX_LIMIT;
		if (n > STACK_FRAMES) n = STACK_FRAMES;
		return n;
	endfunction

	// Depth-first search from every unvisited root in ascending order, with an explicit stack
	// of (vertex, next neighbour) frames. Any edge into a vertex on the current path closes a
	// cycle, a self-loop included.
	function automatic logic search_for_cycle();
		int               n;
		int               depth;
		logic             found;
		dgcd_pkg::row_t   seen;
		dgcd_pkg::row_t   path;
		dgcd_pkg::frame_t cur;
		dgcd_pkg::frame_t stack_frames [STACK_FRAMES];
		n     = live_vertices();
		depth = 0;
		found = 1'b0;
		seen  = '0;
		path  = '0;
		for (int root = 0; root < n && !found; root++) begin
			if (!seen[root[5:0]]) begin
				seen[root[5:0]] = 1'b1;
				path[root[5:0]] = 1'b1;
				stack_frames[0].v = root[5:0];
				stack_frames[0].k = '0;
				depth = 1;
				while (depth > 0 && !found) begin
					cur = stack_frames[depth-1];
					if (cur.k >= n) begin
						// Every neighbour tried: the vertex leaves the path.
						path[cur.v] = 1'b0;
						depth--;
					end else begin
						stack_frames[depth-1].k = cur.k + 7'd1;
						if (graph_rows[cur.v][cur.k[5:0]]) begin
							if (path[cur.k[5:0]]) begin
								found = 1'b1;
							end else if (!seen[cur.k[5:0]] && depth < STACK_FRAMES) begin
								seen[cur.k[5:0]] = 1'b1;
								path[cur.k[5:0]] = 1'b1;
								stack_frames[depth].v = cur.k[5:0];
								stack_frames[depth].k = '0;
								depth++;
							end
						end
					end
				end
			end
		end
		return found;
	endfunction

	function automatic script_row_t add_row(input int src, input int dst);
		script_row_t r;
		r        = '0;
		r.kind   = STEP_BEAT;
		r.act    = dgcd_pkg::ACT_ADD;
		r.src    = src[5:0];
		r.dst    = dst[5:0];
		return r;
	endfunction

	// The edge fields of a check carry random values, which the block must ignore.
	function automatic script_row_t check_row(input logic known, input logic answer);
		script_row_t r;
		r        = '0;
		r.kind   = STEP_BEAT;
		r.act    = dgcd_pkg::ACT_CHECK;
		r.src    = 6'($urandom_range(0, 63));
		r.dst    = 6'($urandom_range(0, 63));
		r.known  = known;
		r.answer = answer;
		return r;
	endfunction

	function automatic script_row_t count_row(input int value);
		script_row_t r;
		r        = '0;
		r.kind   = STEP_COUNT;
		r.count  = value[6:0];
		return r;
	endfunction

	// Appends one row to the end of the directed script.
	function automatic void queue_step(input script_row_t r);
		script = {script, r};
	endfunction

	// Present one beat and hold it until the block takes it. On acceptance the predictor
	// applies the beat: an add in range updates the matrix, a check queues its answer.
	task automatic send_item(input logic act, input logic [5:0] src, input logic [5:0] dst,
			input logic known, input logic answer);
		in_valid  <= 1'b1;
		action    <= act;
		edge_from <= src;
		edge_to   <= dst;
		do @(posedge clk); while (!in_ready);
		if (act == dgcd_pkg::ACT_CHECK) begin
			cycle_answers = {cycle_answers, (known ? answer : search_for_cycle())};
			checks_sent++;
			changing_beats++;
		end else if (src < live_vertices() && dst < live_vertices()) begin
			graph_rows[src][dst] = 1'b1;
			edges_stored++;
			changing_beats++;
		end else begin
			edges_dropped++;
		end
	endtask

	// Sender pacing: beats go out in bursts of random length separated by random gaps. When
	// the burst carries on, valid simply stays high for the next beat.
	task automatic after_beat(input logic steady);
		if (steady) begin
			// No idling at all during this stretch.
		end else if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 20);
		end
	endtask

	// Stop sending until every owed answer has come back, then leave room for a stored add
	// that may still be writing its row.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (cycle_answers.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(input logic [6:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		set_count = value;
		count_writes++;
	endtask

	// The receiver keeps switching at random between its behaviours: always ready, coin-flip
	// ready, mostly stalled, or ready with occasional long stalls.
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(50, 400);
		end else begin
			rx_left--;
		end
		case (rx_mode)
			0: begin
				out_ready <= 1'b1;
			end
			1: begin
				out_ready <= 1'($urandom_range(0, 1));
			end
			2: begin
				out_ready <= ($urandom_range(0, 3) == 0);
			end
			default: begin
				if (rx_hold > 0) begin
					out_ready <= 1'b0;
					rx_hold--;
				end else begin
					out_ready <= 1'b1;
					rx_hold = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0;
				end
			end
		endcase
	end

	// Every accepted result beat is matched against the oldest owed answer.
	always @(posedge clk) begin : result_check
		logic want;
		if (arst_n && out_valid && out_ready) begin
			if (cycle_answers.size() == 0) begin
				$display("%0t: result beat with no check outstanding: expected none, got %0b",
					$time, has_cycle);
				mismatches++;
			end else begin
				want = cycle_answers.pop_front();
				if (has_cycle !== want) begin
					$display("%0t: has_cycle mismatch: expected %0b, got %0b",
						$time, want, has_cycle);
					mismatches++;
				end
				if (has_cycle === CYCLE) cycles_seen++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: run exceeded %0d cycles, %0d answers still owed",
				$time, CYCLE_LIMIT, cycle_answers.size());
			$display("FAIL directed_graph_cycle_detect");
			$finish;
		end
	end

	initial begin
		int          target;
		int          phases;
		int          phase_len;
		int          back_floor;
		int          roll;
		int          n;
		int          src;
		int          dst;
		logic        steady;
		script_row_t r;

		foreach (graph_rows[i]) graph_rows[i] = '0;

		// Directed part. After reset the count is 64 and the matrix is empty. The pair
		// 0 <-> 63 and the self-loop on 62 stay stored for the rest of the run, so counts of
		// 63 and above always see a cycle; lower counts hide them.
		queue_step(check_row(TYPED, NO_CYCLE));
		queue_step(add_row(0, 63));
		queue_step(add_row(63, 0));
		queue_step(check_row(TYPED, CYCLE));
		// Lowering the count hides the stored edges into vertex 63.
		queue_step(count_row(63));
		queue_step(check_row(TYPED, NO_CYCLE));
		// A self-loop is a cycle; the duplicate changes nothing, and an edge into a vertex
		// past the count is dropped.
		queue_step(add_row(62, 62));
		queue_step(add_row(62, 62));
		queue_step(add_row(62, 63));
		queue_step(check_row(TYPED, CYCLE));
		queue_step(count_row(62));
		queue_step(check_row(TYPED, NO_CYCLE));
		// A count of zero leaves no vertices: every add is dropped and a check finds nothing.
		queue_step(count_row(0));
		queue_step(add_row(0, 0));
		queue_step(check_row(TYPED, NO_CYCLE));
		// A single vertex: an edge to vertex 1 is out of range.
		queue_step(count_row(1));
		queue_step(add_row(0, 1));
		queue_step(check_row(TYPED, NO_CYCLE));
		// The largest count saturates to the matrix size, so the stored pair shows again.
		queue_step(count_row(127));
		queue_step(check_row(TYPED, CYCLE));
		// A short chain closed by a back edge, answered by the predictor.
		queue_step(count_row(62));
		queue_step(add_row(59, 60));
		queue_step(add_row(60, 61));
		queue_step(check_row(PREDICTED, NO_CYCLE));
		queue_step(add_row(61, 59));
		queue_step(check_row(PREDICTED, NO_CYCLE));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			r = script[i];
			if (r.kind == STEP_COUNT) begin
				drain_results();
				write_count(r.count);
			end else begin
				send_item(r.act, r.src, r.dst, r.known, r.answer);
				after_beat(1'b0);
			end
		end

		// Random part, in phases of one vertex count each. Forward edges (lower to higher
		// vertex) never close a cycle, so the searches run deep over acyclic graphs. Back
		// edges only start at or above a floor that sinks slowly from phase to phase: a cycle
		// stays stored for good, and counts at or below the floor still see an acyclic graph.
		target = changing_beats + RANDOM_BEATS;
		phases = 0;
		while (changing_beats < target) begin
			phases++;
			drain_results();
			roll = $urandom_range(0, 99);
			if (roll < 6) write_count(7'd0);
			else if (roll < 14) write_count(7'($urandom_range(62, 127)));
			else if (roll < 30) write_count(7'($urandom_range(1, 8)));
			else write_count(7'($urandom_range(9, 61)));
			steady     = ($urandom_range(0, 3) == 0);
			back_floor = (58 - phases > 20) ? 58 - phases : 20;
			phase_len  = $urandom_range(40, 110);
			for (int j = 0; j < phase_len && changing_beats < target; j++) begin
				n    = live_vertices();
				roll = $urandom_range(0, 99);
				if (roll < 10 || (n < 2 && roll < 40)) begin
					send_item(dgcd_pkg::ACT_CHECK, 6'($urandom_range(0, 63)),
						6'($urandom_range(0, 63)), PREDICTED, NO_CYCLE);
				end else if ((roll < 13 || n < 2) && n < dgcd_pkg::VERTEX_LIMIT) begin
					// Noise: at least one endpoint past the count, so the add is dropped.
					if ($urandom_range(0, 1)) begin
						src = $urandom_range(n, 63);
						dst = $urandom_range(0, 63);
					end else begin
						src = $urandom_range(0, 63);
						dst = $urandom_range(n, 63);
					end
					send_item(dgcd_pkg::ACT_ADD, src[5:0], dst[5:0], PREDICTED, NO_CYCLE);
				end else if (roll < 16 && n - 1 >= back_floor) begin
					src = $urandom_range(back_floor, n - 1);
					dst = $urandom_range(0, src);
					send_item(dgcd_pkg::ACT_ADD, src[5:0], dst[5:0], PREDICTED, NO_CYCLE);
				end else begin
					// Mostly short hops, which build long paths; sometimes a far jump.
					src = $urandom_range(0, n - 2);
					if ($urandom_range(0, 9) < 7) begin
						dst = src + $urandom_range(1, 6);
						if (dst > n - 1) dst = n - 1;
					end else begin
						dst = $urandom_range(src + 1, n - 1);
					end
					send_item(dgcd_pkg::ACT_ADD, src[5:0], dst[5:0], PREDICTED, NO_CYCLE);
				end
				after_beat(steady);
				// Now and then the sender holds off until every answer is in.
				if ($urandom_range(0, 99) < 2) drain_results();
			end
		end

		drain_results();
		repeat (20) @(posedge clk);

		$display("Covered %0d stored and %0d dropped edge adds, %0d checks (%0d cycles found),",
			edges_stored, edges_dropped, checks_sent, cycles_seen);
		$display("with %0d vertex-count writes over %0d random phases.", count_writes, phases);
		if (mismatches == 0) begin
			$display("PASS directed_graph_cycle_detect");
		end else begin
			$display("FAIL directed_graph_cycle_detect");
		end
		$finish;
	end

endmodule
